// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int TAG_WIDTH_DEF = 32;

    localparam int NUM_CLASSES   = 4;
    localparam int CLASS_W       = 2;
    localparam int FIELD_TAG_W   = 32;
    localparam int LIVE_W        = 6;
    localparam int STATUS_W      = 2;

    // tdata on both sides: tag, class, (live count on the master side)
    localparam int S_DATA_W      = 40;
    localparam int M_DATA_W      = 40;

    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_SERVED   = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_SEND = 2'b10
    } fsm_t;

endpackage

// ===== hw/rtl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue, lowest class first, arrival order within a class
// ----------------------------------------------------------------------------
// One word in, one result word out. The queue holds up to DEPTH live entries
// in a single synchronous memory split into one ring per class, so an insert
// appends at its class tail and a remove reads the head of the lowest
// non-empty class; both orders match a stably sorted array. The result of an
// item is presented the cycle after it is accepted, and a new word is taken
// in the same cycle the previous result is taken, so the block sustains one
// item per cycle while the output side keeps up. The single memory read port
// with its registered read output sets that figure. No clearing pass is needed
// after reset: per-class counters alone mark which entries are live.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TAG_WIDTH = TAG_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // entry_tag[31:0], entry_class[33:32], zero pad
    input  logic [0:0]          s_axis_tuser,   // kind[0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // served_tag[31:0], served_class[33:32],
                                                // live_count[39:34]
    output logic [STATUS_W-1:0] m_axis_tuser    // status[1:0]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MEM_ENTRIES = NUM_CLASSES * (2 ** AW);

    // ring storage, address is {class, slot}
    logic [TAG_WIDTH-1:0] mem [MEM_ENTRIES];

    fsm_t                state_reg, state_next;
    logic [AW-1:0]       head_reg  [NUM_CLASSES];
    logic [CW-1:0]       ccount_reg[NUM_CLASSES];
    logic [CW-1:0]       total_reg;
    logic [TAG_WIDTH-1:0] rd_data_reg;
    status_t             status_reg;
    logic [CLASS_W-1:0]  sclass_reg;

    logic                in_fire;
    kind_t               in_kind;
    logic [CLASS_W-1:0]  in_class;
    logic [63:0]         in_tag_ext;
    logic [CLASS_W-1:0]  sel_class;
    logic [AW:0]         tail_sum;
    logic [AW-1:0]       tail_slot;
    logic                is_full;
    logic                is_empty;
    logic [63:0]         out_tag_ext;
    logic [63:0]         live_ext;

    assign s_axis_tready = (state_reg == FSM_IDLE) || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_kind       = kind_t'(s_axis_tuser[0]);
    assign in_class      = s_axis_tdata[FIELD_TAG_W +: CLASS_W];
    assign in_tag_ext    = 64'(s_axis_tdata[FIELD_TAG_W-1:0]);

    assign is_full  = (total_reg == CW'(DEPTH));
    assign is_empty = (total_reg == '0);

    // lowest non-empty class is served first
    always_comb
    begin
        sel_class = CLASS_W'(NUM_CLASSES - 1);
        priority if (ccount_reg[0] != '0) sel_class = CLASS_W'(0);
        else if (ccount_reg[1] != '0)     sel_class = CLASS_W'(1);
        else if (ccount_reg[2] != '0)     sel_class = CLASS_W'(2);
        else                              sel_class = CLASS_W'(3);
    end

    // tail slot of the inserted class, wrapped once
    always_comb
    begin
        tail_sum = (AW+1)'(head_reg[in_class]) + (AW+1)'(ccount_reg[in_class]);
        if (tail_sum >= (AW+1)'(DEPTH))
        begin
            tail_sum = tail_sum - (AW+1)'(DEPTH);
        end
        tail_slot = tail_sum[AW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        if (in_fire)
        begin
            state_next = FSM_SEND;
        end
        else if (m_axis_tready)
        begin
            state_next = FSM_IDLE;
        end
    end

    // memory port: at most one write or one read per accepted word
    always_ff @(posedge clk)
    begin
        if (in_fire && (in_kind == KIND_INSERT) && !is_full)
        begin
            mem[{in_class, tail_slot}] <= in_tag_ext[TAG_WIDTH-1:0];
        end
        if (in_fire && (in_kind == KIND_REMOVE) && !is_empty)
        begin
            rd_data_reg <= mem[{sel_class, head_reg[sel_class]}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (in_kind == KIND_INSERT)
            begin
                status_reg <= is_full ? STAT_FULL : STAT_INSERTED;
                sclass_reg <= '0;
            end
            else
            begin
                status_reg <= is_empty ? STAT_EMPTY : STAT_SERVED;
                sclass_reg <= is_empty ? '0 : sel_class;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            total_reg <= '0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c]   <= '0;
                ccount_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                if ((in_kind == KIND_INSERT) && !is_full)
                begin
                    ccount_reg[in_class] <= ccount_reg[in_class] + CW'(1);
                    total_reg            <= total_reg + CW'(1);
                end
                else if ((in_kind == KIND_REMOVE) && !is_empty)
                begin
                    ccount_reg[sel_class] <= ccount_reg[sel_class] - CW'(1);
                    total_reg             <= total_reg - CW'(1);
                    if (head_reg[sel_class] == AW'(DEPTH - 1))
                    begin
                        head_reg[sel_class] <= '0;
                    end
                    else
                    begin
                        head_reg[sel_class] <= head_reg[sel_class] + AW'(1);
                    end
                end
            end
        end
    end

    // live count is taken after the item, so it follows total_reg directly
    assign out_tag_ext = (status_reg == STAT_SERVED) ? 64'(rd_data_reg) : 64'd0;
    assign live_ext    = 64'(total_reg);

    assign m_axis_tvalid = (state_reg == FSM_SEND);
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {live_ext[LIVE_W-1:0], sclass_reg, out_tag_ext[FIELD_TAG_W-1:0]};

endmodule
